### design/tpsd_pkg.sv
// Shared types and constants for the TGA pixel stream decoder.
`timescale 1ns / 1ps

package tpsd_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 16;
  localparam int OUTQ_DEPTH          = 4;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_PAL   = 2'd1,
    OP_START = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_SIZE  = 3'd0,
    CFG_RLE_MODE    = 3'd1,
    CFG_USE_PALETTE = 3'd2,
    CFG_PAL_LENGTH  = 3'd3,
    CFG_WIDTH       = 3'd4,
    CFG_HEIGHT      = 3'd5,
    CFG_TOP_DOWN    = 3'd6
  } cfg_idx_e;

  localparam logic [1:0] PS_8  = 2'd0;
  localparam logic [1:0] PS_16 = 2'd1;
  localparam logic [1:0] PS_24 = 2'd2;
  localparam logic [1:0] PS_32 = 2'd3;

  localparam logic [6:0] PKT_COUNT_MASK = 7'h7F;
  localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;

  // Decoded pixel as it leaves the output queue.
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run_count;
    logic [15:0] dest_x;
    logic [15:0] dest_y;
    logic        image_done;
  } pix_t;

  // Result request from the decoder; color comes from the palette when use_pal.
  typedef struct packed {
    logic        valid;
    logic        use_pal;
    pix_t        pix;
  } res_t;

endpackage

### design/tpsd_pal_mem.sv
// Palette memory: one write port, one registered read port.
`timescale 1ns / 1ps

module tpsd_pal_mem import tpsd_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
  localparam int PAL_AW = $clog2(PALETTE_ENTRIES)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [PAL_AW-1:0] waddr_i,
  input  logic [23:0]       wdata_i,
  input  logic              re_i,
  input  logic [PAL_AW-1:0] raddr_i,
  output logic [23:0]       rdata_o
);

  logic [23:0] mem [PALETTE_ENTRIES];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/tpsd_decode.sv
// Byte decoder: config registers, packet and pixel assembly, position counters.
`timescale 1ns / 1ps

module tpsd_decode import tpsd_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
  localparam int PAL_AW = $clog2(PALETTE_ENTRIES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  room_i,
  output logic                  in_ready_o,
  input  logic [1:0]            opcode_i,
  input  logic [7:0]            data_byte_i,
  input  logic [7:0]            palette_index_i,
  input  logic [23:0]           palette_color_i,
  output logic                  pal_we_o,
  output logic [PAL_AW-1:0]     pal_waddr_o,
  output logic [23:0]           pal_wdata_o,
  output logic                  pal_re_o,
  output logic [PAL_AW-1:0]     pal_raddr_o,
  output res_t                  res_o
);

  // config
  logic [1:0]  psize_q;
  logic        rle_q;
  logic        use_pal_q;
  logic [8:0]  pal_len_q;
  logic [15:0] width_q;
  logic [15:0] height_q;
  logic        top_down_q;

  // decode state
  logic [23:0] partial_q, partial_d;
  logic [1:0]  bip_q, bip_d;
  logic        await_q, await_d;
  logic        rep_q, rep_d;
  logic [7:0]  ppl_q, ppl_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic        fin_q, fin_d;
  logic        busy_q, busy_d;
  logic [16:0] pos_q, pos_d;

  logic        accept;
  op_e         op;
  logic        left_zero;
  logic [15:0] rows_below;
  logic [31:0] left;
  logic [7:0]  px [4];
  logic [15:0] v16;
  logic [7:0]  run;
  logic        done;
  logic [16:0] pos;
  logic [16:0] pos1;
  logic        pal_ok;

  assign in_ready_o = !busy_q && room_i;
  assign accept     = in_valid_i && in_ready_o;
  assign op         = op_e'(opcode_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psize_q    <= PS_32;
      rle_q      <= 1'b0;
      use_pal_q  <= 1'b0;
      pal_len_q  <= '0;
      width_q    <= 16'd1;
      height_q   <= 16'd1;
      top_down_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PIXEL_SIZE:  psize_q    <= cfg_data_i[1:0];
        CFG_RLE_MODE:    rle_q      <= cfg_data_i[0];
        CFG_USE_PALETTE: use_pal_q  <= cfg_data_i[0];
        CFG_PAL_LENGTH:  pal_len_q  <= cfg_data_i[8:0];
        CFG_WIDTH:       width_q    <= cfg_data_i;
        CFG_HEIGHT:      height_q   <= cfg_data_i;
        CFG_TOP_DOWN:    top_down_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign left_zero  = (width_q == '0) || (height_q == '0) ||
                      (row_q >= height_q) || (col_q >= width_q);
  assign rows_below = height_q - 16'd1 - row_q;
  assign left       = 32'(rows_below) * 32'(width_q) + 32'(width_q - col_q);

  always_comb begin
    px[0] = partial_q[7:0];
    px[1] = partial_q[15:8];
    px[2] = partial_q[23:16];
    px[3] = 8'd0;
    px[bip_q] = data_byte_i;
  end
  assign v16 = {px[1], px[0]};

  always_comb begin
    partial_d = partial_q;
    bip_d     = bip_q;
    await_d   = await_q;
    rep_d     = rep_q;
    ppl_d     = ppl_q;
    col_d     = col_q;
    row_d     = row_q;
    fin_d     = fin_q;
    busy_d    = busy_q;
    pos_d     = pos_q;
    pal_we_o    = 1'b0;
    pal_waddr_o = palette_index_i[PAL_AW-1:0];
    pal_wdata_o = palette_color_i;
    pal_re_o    = 1'b0;
    pal_raddr_o = px[0][PAL_AW-1:0];
    pal_ok      = ({1'b0, px[0]} < pal_len_q) &&
                  ({1'b0, px[0]} < 9'(PALETTE_ENTRIES));
    res_o       = '0;
    run         = 8'd1;
    done        = 1'b0;
    pos         = '0;
    pos1        = '0;

    if (busy_q) begin
      if (pos_q < 17'(width_q)) begin
        col_d  = pos_q[15:0];
        busy_d = 1'b0;
      end else begin
        pos_d = pos_q - 17'(width_q);
        row_d = row_q + 16'd1;
      end
    end else if (accept) begin
      unique case (op)
        OP_PAL: begin
          pal_we_o = ({1'b0, palette_index_i} < 9'(PALETTE_ENTRIES));
        end
        OP_START: begin
          partial_d = '0;
          bip_d     = '0;
          await_d   = 1'b1;
          rep_d     = 1'b0;
          ppl_d     = '0;
          col_d     = '0;
          row_d     = '0;
          fin_d     = 1'b0;
        end
        OP_PIXEL: begin
          if (!fin_q) begin
            if (left_zero) begin
              fin_d = 1'b1;
            end else if (rle_q && await_q) begin
              await_d = 1'b0;
              rep_d   = data_byte_i[7];
              ppl_d   = {1'b0, data_byte_i[6:0] & PKT_COUNT_MASK} + 8'd1;
            end else if (bip_q < psize_q) begin
              case (bip_q)
                2'd0:    partial_d[7:0]   = data_byte_i;
                2'd1:    partial_d[15:8]  = data_byte_i;
                default: partial_d[23:16] = data_byte_i;
              endcase
              bip_d = bip_q + 2'd1;
            end else begin
              partial_d = '0;
              bip_d     = '0;
              res_o.valid = 1'b1;
              res_o.pix.alpha = ALPHA_OPAQUE;
              case (psize_q)
                PS_8: begin
                  if (use_pal_q) begin
                    res_o.use_pal = pal_ok;
                    pal_re_o      = pal_ok;
                  end else begin
                    res_o.pix.red   = px[0];
                    res_o.pix.green = px[0];
                    res_o.pix.blue  = px[0];
                  end
                end
                PS_16: begin
                  res_o.pix.alpha = v16[15] ? ALPHA_OPAQUE : 8'd0;
                  res_o.pix.red   = {v16[14:10], 3'b000};
                  res_o.pix.green = {v16[9:5], 3'b000};
                  res_o.pix.blue  = {v16[4:0], 3'b000};
                end
                PS_24: begin
                  res_o.pix.blue  = px[0];
                  res_o.pix.green = px[1];
                  res_o.pix.red   = px[2];
                end
                default: begin
                  res_o.pix.blue  = px[0];
                  res_o.pix.green = px[1];
                  res_o.pix.red   = px[2];
                  res_o.pix.alpha = px[3];
                end
              endcase

              if (rle_q) begin
                if (rep_q) begin
                  run     = (ppl_q != '0) ? ppl_q : 8'd1;
                  ppl_d   = '0;
                  await_d = 1'b1;
                end else begin
                  if (ppl_q > 8'd1) begin
                    ppl_d = ppl_q - 8'd1;
                  end else begin
                    ppl_d   = '0;
                    await_d = 1'b1;
                  end
                end
              end
              if (32'(run) > left) begin
                run = left[7:0];
              end
              done = (32'(run) == left);

              res_o.pix.run_count  = run;
              res_o.pix.dest_x     = col_q;
              res_o.pix.dest_y     = top_down_q ? row_q : rows_below;
              res_o.pix.image_done = done;

              if (done) begin
                fin_d = 1'b1;
                col_d = '0;
                row_d = '0;
              end else begin
                pos  = 17'(col_q) + 17'(run);
                pos1 = pos - 17'(width_q);
                if (pos < 17'(width_q)) begin
                  col_d = pos[15:0];
                end else begin
                  row_d = row_q + 16'd1;
                  if (pos1 < 17'(width_q)) begin
                    col_d = pos1[15:0];
                  end else begin
                    busy_d = 1'b1;
                    pos_d  = pos1;
                  end
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      bip_q     <= '0;
      await_q   <= 1'b1;
      rep_q     <= 1'b0;
      ppl_q     <= '0;
      col_q     <= '0;
      row_q     <= '0;
      fin_q     <= 1'b0;
      busy_q    <= 1'b0;
      pos_q     <= '0;
    end else begin
      partial_q <= partial_d;
      bip_q     <= bip_d;
      await_q   <= await_d;
      rep_q     <= rep_d;
      ppl_q     <= ppl_d;
      col_q     <= col_d;
      row_q     <= row_d;
      fin_q     <= fin_d;
      busy_q    <= busy_d;
      pos_q     <= pos_d;
    end
  end

endmodule

### design/tpsd_outq.sv
// Result stage: merges palette read data, then queues results for the output.
`timescale 1ns / 1ps

module tpsd_outq import tpsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  res_t        res_i,
  input  logic [23:0] pal_rdata_i,
  output logic        room_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pix_t        out_pix_o
);

  localparam int PW = $clog2(OUTQ_DEPTH);
  localparam int CW = $clog2(OUTQ_DEPTH + 1);

  res_t            p_q;
  logic            p_valid_q;
  pix_t            p_pix;
  pix_t            q_mem [OUTQ_DEPTH];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]   cnt_q;
  logic            push, pop;

  always_comb begin
    p_pix = p_q.pix;
    if (p_q.use_pal) begin
      p_pix.red   = pal_rdata_i[23:16];
      p_pix.green = pal_rdata_i[15:8];
      p_pix.blue  = pal_rdata_i[7:0];
    end
  end

  assign push        = p_valid_q;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_pix_o   = q_mem[rptr_q];
  assign room_o      = (CW'(32'(cnt_q) + 32'(p_valid_q))) < CW'(OUTQ_DEPTH);

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      p_q <= res_i;
    end
    if (push) begin
      q_mem[wptr_q] <= p_pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      wptr_q    <= '0;
      rptr_q    <= '0;
      cnt_q     <= '0;
    end else begin
      p_valid_q <= res_i.valid;
      if (push) begin
        wptr_q <= wptr_q + PW'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

### design/tga_pixel_stream_decoder_unit.sv
// Top level of the TGA pixel stream decoder.
// Takes one request per cycle while s_axis_tready is high: a pixel-data byte,
// a palette write or an image start, selected by s_axis_tuser. A pixel result is
// registered together with the palette read data, then written into the output
// queue; up to four results queue at the output, so input continues while a
// result waits. A run that crosses two or more row ends stalls input while the
// row-wrap subtract loop steps through the row ends. The palette is not cleared
// at reset; entries must be written before use.
`timescale 1ns / 1ps

module tga_pixel_stream_decoder_unit import tpsd_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // data_byte[7:0], palette_index[15:8], palette_color[39:16]
  input  logic [39:0]           s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // red[7:0], green[15:8], blue[23:16], alpha[31:24], run_count[39:32],
  // dest_x[55:40], dest_y[71:56]
  output logic [71:0]           m_axis_tdata,
  output logic                  m_axis_tlast
);

  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

  logic              room;
  logic              pal_we;
  logic [PAL_AW-1:0] pal_waddr;
  logic [23:0]       pal_wdata;
  logic              pal_re;
  logic [PAL_AW-1:0] pal_raddr;
  logic [23:0]       pal_rdata;
  res_t              res;
  pix_t              pix;

  tpsd_decode #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (s_axis_tvalid),
    .room_i          (room),
    .in_ready_o      (s_axis_tready),
    .opcode_i        (s_axis_tuser),
    .data_byte_i     (s_axis_tdata[7:0]),
    .palette_index_i (s_axis_tdata[15:8]),
    .palette_color_i (s_axis_tdata[39:16]),
    .pal_we_o        (pal_we),
    .pal_waddr_o     (pal_waddr),
    .pal_wdata_o     (pal_wdata),
    .pal_re_o        (pal_re),
    .pal_raddr_o     (pal_raddr),
    .res_o           (res)
  );

  tpsd_pal_mem #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_pal_mem (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (pal_wdata),
    .re_i    (pal_re),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  tpsd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .pal_rdata_i (pal_rdata),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pix_o   (pix)
  );

  assign m_axis_tdata = {pix.dest_y, pix.dest_x, pix.run_count,
                         pix.alpha, pix.blue, pix.green, pix.red};
  assign m_axis_tlast = pix.image_done;

endmodule
